/* design/mahs_pkg.sv */
// Shared widths, register indexes and reset values of the moving-average lamp switch.
package mahs_pkg;

	localparam int SAMPLE_W  = 12;
	localparam int SUM_W     = 16;
	localparam int STEP_W    = $clog2(SUM_W);
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_DARK  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LIGHT = 2'd1;

	localparam logic [SAMPLE_W-1:0] DARK_RESET  = 12'd1200;
	localparam logic [SAMPLE_W-1:0] LIGHT_RESET = 12'd1600;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_READ = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

endpackage

/* design/moving_average_hysteresis_switch_core.sv */
// Moving-average light switch with a hysteresis lamp flag, built around a sample RAM.
// Each transaction passes through the ST_READ state, the 16-step radix-2 divider in ST_DIV
// and ST_DONE, where its result is registered at the output.
// The input stalls while an item is in work; an item that finds the previous result
// still waiting at the output holds in its last state until that result is taken.
// Reset clears control state, sets the thresholds to 1200 and 1600 and turns the lamp off.
// The sample RAM is not cleared; the fill count hides entries that were never written.
module moving_average_hysteresis_switch_core #(
	parameter int WINDOW = 10
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [mahs_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [mahs_pkg::SAMPLE_W-1:0]        cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [mahs_pkg::SAMPLE_W-1:0]        sample,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [mahs_pkg::SAMPLE_W-1:0]        average,
	output logic                                 lamp_on,
	output logic                                 lamp_changed
);

	localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int CNT_W  = $clog2(WINDOW + 1);
	localparam int SW     = mahs_pkg::SAMPLE_W;
	localparam int SUMW   = mahs_pkg::SUM_W;

	mahs_pkg::state_t state_q;

	logic [SW-1:0]                   dark_q;
	logic [SW-1:0]                   light_q;
	logic [SW-1:0]                   sample_q;
	logic [SLOT_W-1:0]               slot_q;
	logic [CNT_W-1:0]                fill_q;
	logic [SUMW-1:0]                 sum_q;
	logic [SUMW-1:0]                 quot_q;
	logic [CNT_W-1:0]                rem_q;
	logic [CNT_W-1:0]                den_q;
	logic [mahs_pkg::STEP_W-1:0]     step_q;
	logic                            lamp_q;
	logic                            out_valid_q;
	logic [SW-1:0]                   average_q;
	logic                            lamp_changed_q;

	logic [SW-1:0]                   ram_rdata;
	logic                            ram_we;
	logic                            full;
	logic [SW-1:0]                   old_sample;
	logic [SUMW-1:0]                 sum_new;
	logic [CNT_W-1:0]                count_new;
	logic [CNT_W:0]                  trial;
	logic                            trial_ge;
	logic [SW-1:0]                   avg;
	logic                            lamp_next;
	logic                            out_free;

	mahs_ram #(
		.WIDTH (SW),
		.DEPTH (WINDOW)
	) u_ring (
		.clk   (clk),
		.we    (ram_we),
		.waddr (slot_q),
		.wdata (sample_q),
		.raddr (slot_q),
		.rdata (ram_rdata)
	);

	assign in_stall  = (state_q != mahs_pkg::ST_IDLE);
	assign ram_we    = (state_q == mahs_pkg::ST_READ);
	assign full      = (fill_q == CNT_W'(WINDOW));
	assign old_sample = full ? ram_rdata : '0;
	assign sum_new   = sum_q - SUMW'(old_sample) + SUMW'(sample_q);
	assign count_new = full ? fill_q : fill_q + 1'b1;

	assign trial    = {rem_q, quot_q[SUMW-1]};
	assign trial_ge = (trial >= {1'b0, den_q});

	assign avg       = quot_q[SW-1:0];
	assign lamp_next = lamp_q ? !(avg > light_q) : (avg < dark_q);
	assign out_free  = !out_valid_q || !out_stall;

	assign out_valid    = out_valid_q;
	assign average      = average_q;
	assign lamp_on      = lamp_q;
	assign lamp_changed = lamp_changed_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dark_q  <= mahs_pkg::DARK_RESET;
			light_q <= mahs_pkg::LIGHT_RESET;
		end else if (cfg_we) begin
			if (cfg_index == mahs_pkg::REG_DARK) begin
				dark_q <= cfg_data;
			end else if (cfg_index == mahs_pkg::REG_LIGHT) begin
				light_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mahs_pkg::ST_IDLE;
			slot_q      <= '0;
			fill_q      <= '0;
			sum_q       <= '0;
			step_q      <= '0;
			lamp_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && state_q != mahs_pkg::ST_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				mahs_pkg::ST_IDLE: begin
					if (in_valid) begin
						state_q <= mahs_pkg::ST_READ;
					end
				end
				mahs_pkg::ST_READ: begin
					sum_q  <= sum_new;
					fill_q <= count_new;
					slot_q <= (slot_q == SLOT_W'(WINDOW - 1)) ? '0 : slot_q + 1'b1;
					step_q <= '0;
					state_q <= mahs_pkg::ST_DIV;
				end
				mahs_pkg::ST_DIV: begin
					step_q <= step_q + 1'b1;
					if (step_q == mahs_pkg::STEP_W'(SUMW - 1)) begin
						state_q <= mahs_pkg::ST_DONE;
					end
				end
				mahs_pkg::ST_DONE: begin
					if (out_free) begin
						lamp_q      <= lamp_next;
						out_valid_q <= 1'b1;
						state_q     <= mahs_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= mahs_pkg::ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == mahs_pkg::ST_IDLE && in_valid) begin
			sample_q <= sample;
		end
		if (state_q == mahs_pkg::ST_READ) begin
			quot_q <= sum_new;
			rem_q  <= '0;
			den_q  <= count_new;
		end
		if (state_q == mahs_pkg::ST_DIV) begin
			rem_q  <= trial_ge ? CNT_W'(trial - {1'b0, den_q}) : CNT_W'(trial);
			quot_q <= {quot_q[SUMW-2:0], trial_ge};
		end
		if (state_q == mahs_pkg::ST_DONE && out_free) begin
			average_q      <= avg;
			lamp_changed_q <= (lamp_next != lamp_q);
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(WINDOW))
		else $error("fill count exceeds the window");

	a_slot_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(slot_q) < WINDOW)
		else $error("write slot outside the window");

	a_den_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == mahs_pkg::ST_DIV |-> den_q != '0)
		else $error("divider runs with a zero count");

	a_quot_fits: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == mahs_pkg::ST_DONE |-> quot_q[SUMW-1:SW] == '0)
		else $error("mean does not fit the sample width");

endmodule

/* design/mahs_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
module mahs_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 10
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* tb/moving_average_hysteresis_switch_core_test.sv */
// Self-checking testbench for the moving-average lamp switch with hysteresis thresholds.
`timescale 1ns / 1ps

module moving_average_hysteresis_switch_core_test;

	localparam int WINDOW       = 10;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 30;
	localparam int HOLD_OFF_LEN = 400;
	localparam int PHASE_ITEMS  = 270;

	localparam logic [mahs_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [mahs_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

	typedef enum int {
		LEVEL_UNIFORM,
		LEVEL_NEAR_DARK,
		LEVEL_NEAR_LIGHT,
		LEVEL_STEADY,
		LEVEL_RAIL
	} level_kind_t;

	typedef struct {
		logic [mahs_pkg::SAMPLE_W-1:0] average;
		logic                          lamp_on;
		logic                          lamp_changed;
	} lamp_reading_t;

	logic                           clk;
	logic                           arst_n;
	logic                           cfg_we;
	logic [mahs_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [mahs_pkg::SAMPLE_W-1:0]  cfg_data;
	logic                           in_valid;
	logic                           in_stall;
	logic [mahs_pkg::SAMPLE_W-1:0]  sample;
	logic                           out_valid;
	logic                           out_stall = 1'b0;
	logic [mahs_pkg::SAMPLE_W-1:0]  average;
	logic                           lamp_on;
	logic                           lamp_changed;

	logic [mahs_pkg::SAMPLE_W-1:0] ring_model [WINDOW];
	logic [mahs_pkg::SUM_W-1:0]    sum_model;
	int                            slot_model;
	int                            fill_model;
	logic                          lamp_model;
	logic [mahs_pkg::SAMPLE_W-1:0] dark_model;
	logic [mahs_pkg::SAMPLE_W-1:0] light_model;

	lamp_reading_t expected_readings [$];
	int            error_count     = 0;
	int            cycle_count     = 0;
	int            send_idle_pct   = 0;
	int            recv_stall_pct  = 0;
	int            hold_off_cycles = 0;

	moving_average_hysteresis_switch_core #(
		.WINDOW(WINDOW)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sample(sample),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.average(average),
		.lamp_on(lamp_on),
		.lamp_changed(lamp_changed)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("moving_average_hysteresis_switch_core: mismatch");
			$finish;
		end
	end

	always @(negedge clk) begin
		if (hold_off_cycles > 0) begin
			out_stall = 1'b1;
			hold_off_cycles--;
		end else begin
			out_stall = ($urandom_range(99) < recv_stall_pct);
		end
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("ERROR at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
		error_count++;
	endtask

	function automatic void advance_lamp_model(input logic [mahs_pkg::SAMPLE_W-1:0] value);
		lamp_reading_t reading;
		logic          was_on;
		was_on = lamp_model;
		sum_model = sum_model - mahs_pkg::SUM_W'(ring_model[slot_model])
			+ mahs_pkg::SUM_W'(value);
		ring_model[slot_model] = value;
		slot_model = (slot_model + 1) % WINDOW;
		if (fill_model < WINDOW)
			fill_model++;
		reading.average = mahs_pkg::SAMPLE_W'(int'(sum_model) / fill_model);
		if (!lamp_model && reading.average < dark_model)
			lamp_model = 1'b1;
		else if (lamp_model && reading.average > light_model)
			lamp_model = 1'b0;
		reading.lamp_on = lamp_model;
		reading.lamp_changed = (lamp_model != was_on);
		expected_readings.push_back(reading);
	endfunction

	always @(posedge clk) begin
		lamp_reading_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_readings.size() == 0) begin
				report_mismatch("unexpected transaction, average", average, 0);
			end else begin
				want = expected_readings.pop_front();
				if (average !== want.average)
					report_mismatch("average", average, want.average);
				if (lamp_on !== want.lamp_on)
					report_mismatch("lamp_on", lamp_on, want.lamp_on);
				if (lamp_changed !== want.lamp_changed)
					report_mismatch("lamp_changed", lamp_changed, want.lamp_changed);
			end
		end
	end

	task automatic send_sample(input logic [mahs_pkg::SAMPLE_W-1:0] value);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		sample = value;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		advance_lamp_model(value);
	endtask

	task automatic wait_until_drained();
		@(negedge clk);
		in_valid = 1'b0;
		while (expected_readings.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input logic [mahs_pkg::CFG_IDX_W-1:0] index,
			input logic [mahs_pkg::SAMPLE_W-1:0] value);
		wait_until_drained();
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = index;
		cfg_data = value;
		@(negedge clk);
		cfg_we = 1'b0;
		case (index)
			mahs_pkg::REG_DARK:  dark_model = value;
			mahs_pkg::REG_LIGHT: light_model = value;
			default: ;
		endcase
	endtask

	task automatic test_warm_up_and_equal_means();
		send_sample(12'd1200);
		send_sample(12'd1200);
		send_sample(12'd1199);
		send_sample(12'd2801);
		send_sample(12'd4095);
		send_sample(12'd0);
		repeat (4) send_sample(12'd4095);
		repeat (11) send_sample(12'd4095);
		repeat (4) send_sample(12'd0);
	endtask

	task automatic test_register_writes();
		write_register(REG_SPARE_2, 12'hFFF);
		write_register(REG_SPARE_3, 12'h000);
		repeat (3) send_sample(12'd0);
		repeat (3) send_sample(12'd4095);
		write_register(mahs_pkg::REG_DARK, 12'd0);
		write_register(mahs_pkg::REG_LIGHT, 12'd4095);
		repeat (12) send_sample(12'd0);
		write_register(mahs_pkg::REG_DARK, 12'd4095);
		write_register(mahs_pkg::REG_LIGHT, 12'd0);
		repeat (5) send_sample(12'd2048);
		write_register(mahs_pkg::REG_LIGHT, 12'd4095);
		repeat (12) send_sample(12'd4095);
		write_register(mahs_pkg::REG_DARK, mahs_pkg::DARK_RESET);
		write_register(mahs_pkg::REG_LIGHT, mahs_pkg::LIGHT_RESET);
	endtask

	task automatic test_random_phase(input int sender_pct, input int receiver_pct,
			input int count);
		int          sent;
		int          burst;
		int          base;
		int          level;
		int          a;
		int          b;
		level_kind_t kind;
		a = $urandom_range(4095);
		b = $urandom_range(4095);
		if ($urandom_range(3) != 0 && a > b) begin
			base = a;
			a = b;
			b = base;
		end
		write_register(mahs_pkg::REG_DARK, a[mahs_pkg::SAMPLE_W-1:0]);
		write_register(mahs_pkg::REG_LIGHT, b[mahs_pkg::SAMPLE_W-1:0]);
		send_idle_pct = sender_pct;
		recv_stall_pct = receiver_pct;
		sent = 0;
		while (sent < count) begin
			kind = level_kind_t'($urandom_range(4));
			burst = $urandom_range(1, 16);
			case (kind)
				LEVEL_NEAR_DARK:  base = dark_model;
				LEVEL_NEAR_LIGHT: base = light_model;
				default:          base = $urandom_range(4095);
			endcase
			repeat (burst) begin
				case (kind)
					LEVEL_UNIFORM:    level = $urandom_range(4095);
					LEVEL_NEAR_DARK,
					LEVEL_NEAR_LIGHT: level = base + int'($urandom_range(80)) - 40;
					LEVEL_STEADY:     level = base + int'($urandom_range(8)) - 4;
					default:          level = $urandom_range(1) ? 4095 : 0;
				endcase
				if (level < 0)
					level = 0;
				if (level > 4095)
					level = 4095;
				send_sample(level[mahs_pkg::SAMPLE_W-1:0]);
				sent++;
			end
		end
	endtask

	task automatic test_output_hold_off();
		wait_until_drained();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		@(posedge clk);
		hold_off_cycles = HOLD_OFF_LEN;
		repeat (8) send_sample(12'($urandom_range(4095)));
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = mahs_pkg::REG_DARK;
		cfg_data = '0;
		in_valid = 1'b0;
		sample = '0;
		for (int i = 0; i < WINDOW; i++)
			ring_model[i] = '0;
		sum_model = '0;
		slot_model = 0;
		fill_model = 0;
		lamp_model = 1'b0;
		dark_model = mahs_pkg::DARK_RESET;
		light_model = mahs_pkg::LIGHT_RESET;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		test_warm_up_and_equal_means();
		test_register_writes();
		test_random_phase(30, 47, PHASE_ITEMS);
		test_output_hold_off();
		test_random_phase(47, 30, PHASE_ITEMS);
		test_random_phase(0, 0, PHASE_ITEMS);
		wait_until_drained();

		if (error_count == 0)
			$display("moving_average_hysteresis_switch_core: match");
		else
			$display("moving_average_hysteresis_switch_core: mismatch");
		$finish;
	end

endmodule
